@@ design/modbus_rtu_request_framer_defines.svh @@
// ----------------------------------------------------------------------------
// Modbus RTU request framer assertion macros
// Shared property macros for the checker; all use clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH
`define MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MBRF_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("modbus framer check failed");

// Next-cycle implication, disabled during reset.
`define MBRF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("modbus framer check failed");

`endif

@@ design/mbrf_pkg.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU request framer package
// Frame codes, CRC constants and the control types shared by the modules.
// ----------------------------------------------------------------------------
package mbrf_pkg;

	localparam logic [1:0] CMD_READ_HOLD    = 2'd0;
	localparam logic [1:0] CMD_WRITE_SINGLE = 2'd1;
	localparam logic [1:0] CMD_WRITE_MULTI  = 2'd2;
	localparam logic [1:0] CMD_RESERVED     = 2'd3;

	localparam logic [7:0] FC_READ_HOLD    = 8'h03;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
	localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] SLAVE_ADDR_RESET = 8'h01;

	// Header byte positions.
	localparam logic [2:0] HDR_SLAVE    = 3'd0;
	localparam logic [2:0] HDR_FUNC     = 3'd1;
	localparam logic [2:0] HDR_ADDR_HI  = 3'd2;
	localparam logic [2:0] HDR_ADDR_LO  = 3'd3;
	localparam logic [2:0] HDR_COUNT_HI = 3'd4;
	localparam logic [2:0] HDR_COUNT_LO = 3'd5;
	localparam logic [2:0] HDR_BYTE_CNT = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_DATA,
		ST_CRC_LO,
		ST_CRC_HI
	} seq_state_t;

	typedef struct packed {
		logic       clear;
		logic       update;
		logic [7:0] data;
	} crc_ctrl_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} emit_t;

endpackage

@@ design/mbrf_if.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU request framer channels
// Valid/ready interfaces for the request, frame byte and configuration paths.
// ----------------------------------------------------------------------------
interface mbrf_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] start_addr;
	logic [6:0]  num_regs;
	logic [7:0]  data_byte;
	logic        end_of_data;

	modport source (output valid, cmd, start_addr, num_regs, data_byte, end_of_data,
		input ready);
	modport sink (input valid, cmd, start_addr, num_regs, data_byte, end_of_data,
		output ready);
endinterface

interface mbrf_frm_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;

	modport source (output valid, out_byte, frame_end, input ready);
	modport sink (input valid, out_byte, frame_end, output ready);
endinterface

interface mbrf_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] slave_address;

	modport source (output valid, slave_address, input ready);
	modport sink (input valid, slave_address, output ready);
endinterface

@@ design/mbrf_crc.sv @@
// ----------------------------------------------------------------------------
// CRC-16/MODBUS unit
// Running CRC register shared by all header and data bytes, one per update.
// ----------------------------------------------------------------------------
module mbrf_crc (
	input  logic               clk,
	input  logic               arst_n,
	input  mbrf_pkg::crc_ctrl_t ctrl,
	output logic [15:0]        crc
);
	import mbrf_pkg::*;

	logic [15:0] crc_q;
	logic [15:0] crc_next;

	// Reflected CRC over one byte: eight shift-and-conditional-xor steps.
	always_comb begin
		crc_next = crc_q ^ {8'h00, ctrl.data};
		for (int i = 0; i < 8; i++) begin
			if (crc_next[0]) begin
				crc_next = (crc_next >> 1) ^ CRC_POLY;
			end else begin
				crc_next = crc_next >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctrl.clear) begin
			crc_q <= CRC_INIT;
		end else if (ctrl.update) begin
			crc_q <= crc_next;
		end
	end

	assign crc = crc_q;

endmodule

@@ design/mbrf_seq.sv @@
// ----------------------------------------------------------------------------
// Frame sequencer
// Takes items; walks header, data and CRC bytes one per cycle unless stalled.
// ----------------------------------------------------------------------------
module mbrf_seq (
	input  logic                clk,
	input  logic                arst_n,
	mbrf_req_if.sink            req,
	mbrf_cfg_if.sink            cfg,
	input  logic [15:0]         crc,
	input  logic                emit_ok,
	output mbrf_pkg::emit_t     emit,
	output mbrf_pkg::crc_ctrl_t crc_ctrl
);
	import mbrf_pkg::*;

	seq_state_t  state_q, state_d;
	logic [2:0]  idx_q, idx_d;
	logic [1:0]  kind_q, kind_d;
	logic        open_q, open_d;
	logic [7:0]  slave_q;
	logic [15:0] addr_q;
	logic [6:0]  count_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic        accept;
	logic [7:0]  hdr_byte;
	logic [7:0]  func_code;
	logic [2:0]  hdr_last_idx;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	always_comb begin
		unique case (kind_q)
			CMD_READ_HOLD: begin
				func_code    = FC_READ_HOLD;
				hdr_last_idx = HDR_COUNT_LO;
			end
			CMD_WRITE_SINGLE: begin
				func_code    = FC_WRITE_SINGLE;
				hdr_last_idx = HDR_ADDR_LO;
			end
			default: begin
				func_code    = FC_WRITE_MULTI;
				hdr_last_idx = HDR_BYTE_CNT;
			end
		endcase
	end

	always_comb begin
		unique case (idx_q)
			HDR_SLAVE:    hdr_byte = slave_q;
			HDR_FUNC:     hdr_byte = func_code;
			HDR_ADDR_HI:  hdr_byte = addr_q[15:8];
			HDR_ADDR_LO:  hdr_byte = addr_q[7:0];
			HDR_COUNT_LO: hdr_byte = {1'b0, count_q};
			HDR_BYTE_CNT: hdr_byte = {count_q, 1'b0};
			default:      hdr_byte = 8'h00;
		endcase
	end

	always_comb begin
		state_d         = state_q;
		idx_d           = idx_q;
		kind_d          = kind_q;
		open_d          = open_q;
		emit            = '0;
		crc_ctrl.clear  = 1'b0;
		crc_ctrl.update = 1'b0;
		crc_ctrl.data   = 8'h00;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (open_q) begin
						state_d = ST_DATA;
					end else if (req.cmd != CMD_RESERVED) begin
						state_d = ST_HDR;
						kind_d  = req.cmd;
						idx_d   = HDR_SLAVE;
					end
				end
			end
			ST_HDR: begin
				emit.valid      = 1'b1;
				emit.data       = hdr_byte;
				crc_ctrl.data   = hdr_byte;
				crc_ctrl.update = emit_ok;
				if (emit_ok) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == hdr_last_idx) begin
						state_d = (kind_q == CMD_READ_HOLD) ? ST_CRC_LO : ST_DATA;
					end
				end
			end
			ST_DATA: begin
				emit.valid      = 1'b1;
				emit.data       = data_q;
				crc_ctrl.data   = data_q;
				crc_ctrl.update = emit_ok;
				if (emit_ok) begin
					open_d  = 1'b1;
					state_d = last_q ? ST_CRC_LO : ST_IDLE;
				end
			end
			ST_CRC_LO: begin
				emit.valid = 1'b1;
				emit.data  = crc[7:0];
				if (emit_ok) begin
					state_d = ST_CRC_HI;
				end
			end
			ST_CRC_HI: begin
				emit.valid     = 1'b1;
				emit.data      = crc[15:8];
				emit.last      = 1'b1;
				crc_ctrl.clear = emit_ok;
				if (emit_ok) begin
					open_d  = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= HDR_SLAVE;
			kind_q  <= CMD_READ_HOLD;
			open_q  <= 1'b0;
			slave_q <= SLAVE_ADDR_RESET;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			kind_q  <= kind_d;
			open_q  <= open_d;
			if (cfg.valid && cfg.ready) begin
				slave_q <= cfg.slave_address;
			end
		end
	end

	// No reset: data/last load on every transfer, addr/count only outside a frame.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= req.data_byte;
			last_q <= req.end_of_data;
			if (!open_q) begin
				addr_q  <= req.start_addr;
				count_q <= req.num_regs;
			end
		end
	end

endmodule

@@ design/mbrf_obuf.sv @@
// ----------------------------------------------------------------------------
// Frame byte output register
// Holds one emitted byte until the downstream side takes it.
// ----------------------------------------------------------------------------
module mbrf_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  mbrf_pkg::emit_t emit,
	output logic            emit_ok,
	mbrf_frm_if.source      frm
);
	import mbrf_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       end_q;

	assign emit_ok = !valid_q || frm.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit_ok) begin
			valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ok && emit.valid) begin
			byte_q <= emit.data;
			end_q  <= emit.last;
		end
	end

	assign frm.valid     = valid_q;
	assign frm.out_byte  = byte_q;
	assign frm.frame_end = end_q;

endmodule

@@ design/modbus_rtu_request_framer.sv @@
// The first frame byte passes the sequencer state and the output register.
// An item is accepted, then its bytes are emitted by the sequencer and the
// shared CRC unit, one byte per cycle while the output is not stalled.
// The block is not ready while it emits, so a new item waits for those bytes.
// Reset clears the sequencer, the CRC to 0xFFFF and the slave address to 1.
// ----------------------------------------------------------------------------
// Modbus RTU request framer
// Builds request frames with header, data bytes and CRC-16/MODBUS trailer.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer (
	input  logic       clk,
	input  logic       arst_n,
	mbrf_req_if.sink   req,
	mbrf_cfg_if.sink   cfg,
	mbrf_frm_if.source frm
);
	import mbrf_pkg::*;

	emit_t       emit;
	crc_ctrl_t   crc_ctrl;
	logic        emit_ok;
	logic [15:0] crc;

	mbrf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.crc      (crc),
		.emit_ok  (emit_ok),
		.emit     (emit),
		.crc_ctrl (crc_ctrl)
	);

	mbrf_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.crc    (crc)
	);

	mbrf_obuf u_obuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.emit    (emit),
		.emit_ok (emit_ok),
		.frm     (frm)
	);

endmodule

@@ design/mbrf_checker.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU request framer checker
// Port-level properties of the framer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "modbus_rtu_request_framer_defines.svh"

module mbrf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [1:0] req_cmd,
	input logic       frm_valid,
	input logic       frm_ready,
	input logic [7:0] frm_out_byte,
	input logic       frm_frame_end
);
	import mbrf_pkg::*;

	// A stalled frame byte must hold.
	`MBRF_ASSERT_NEXT(a_frm_hold, frm_valid && !frm_ready, frm_valid && $stable(frm_out_byte) && $stable(frm_frame_end))

	// Every frame needs a CRC low byte first, so two frame ends never follow each other.
	`MBRF_ASSERT_NEXT(a_end_not_repeated, frm_valid && frm_ready && frm_frame_end, !(frm_valid && frm_frame_end))

	// Taking an item with a valid frame kind makes the block busy.
	`MBRF_ASSERT_NEXT(a_busy_after_item, req_valid && req_ready && (req_cmd != CMD_RESERVED), !req_ready)

	// While a frame end byte is valid and the sequencer is busy,
	// no new item is taken.
	`MBRF_ASSERT_SAME(a_no_take_on_end, frm_valid && frm_frame_end && !req_ready, !(req_valid && req_ready))

endmodule

bind modbus_rtu_request_framer mbrf_checker u_mbrf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_cmd       (req.cmd),
	.frm_valid     (frm.valid),
	.frm_ready     (frm.ready),
	.frm_out_byte  (frm.out_byte),
	.frm_frame_end (frm.frame_end)
);

@@ verif/modbus_rtu_request_framer_tb.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU request framer testbench
// Drives request items and slave address writes into the framer, predicts
// every frame byte with its own header and CRC-16 model, and checks the bytes
// that leave the block in order, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer_tb;
	import mbrf_pkg::*;

	localparam int LONG_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES    = 12;
	localparam int MAX_REPORTS      = 200;

	typedef struct {
		logic [1:0]  cmd;
		logic [15:0] addr;
		logic [6:0]  count;
		logic [7:0]  data;
		logic        last;
	} req_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	logic clk;
	logic arst_n;

	mbrf_req_if req_ch ();
	mbrf_cfg_if cfg_ch ();
	mbrf_frm_if frm_ch ();

	modbus_rtu_request_framer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.cfg    (cfg_ch),
		.frm    (frm_ch)
	);

	req_item_t   pending_reqs[$];
	frame_byte_t expected_bytes[$];

	// Predicted framer state.
	logic [7:0]  slave_addr_model;
	logic [15:0] crc_model;
	logic        frame_open_model;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	bit long_hold_req;
	int mismatch_count;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [15:0] crc16_modbus_byte(logic [15:0] crc, logic [7:0] b);
		crc = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
		return crc;
	endfunction

	function automatic void emit_frame_byte(logic [7:0] b);
		expected_bytes.push_back('{data: b, last: 1'b0});
		crc_model = crc16_modbus_byte(crc_model, b);
	endfunction

	function automatic void close_frame();
		expected_bytes.push_back('{data: crc_model[7:0], last: 1'b0});
		expected_bytes.push_back('{data: crc_model[15:8], last: 1'b1});
		crc_model = CRC_INIT;
		frame_open_model = 1'b0;
	endfunction

	function automatic void predict_frame_bytes(req_item_t it);
		logic [7:0] func_code;
		if (frame_open_model) begin
			// Inside a frame every item is a data byte, whatever its cmd.
			emit_frame_byte(it.data);
			if (it.last)
				close_frame();
			return;
		end
		if (it.cmd == CMD_RESERVED)
			return;
		case (it.cmd)
			CMD_READ_HOLD:    func_code = FC_READ_HOLD;
			CMD_WRITE_SINGLE: func_code = FC_WRITE_SINGLE;
			default:          func_code = FC_WRITE_MULTI;
		endcase
		crc_model = CRC_INIT;
		emit_frame_byte(slave_addr_model);
		emit_frame_byte(func_code);
		emit_frame_byte(it.addr[15:8]);
		emit_frame_byte(it.addr[7:0]);
		if (it.cmd == CMD_READ_HOLD) begin
			emit_frame_byte(8'h00);
			emit_frame_byte({1'b0, it.count});
			close_frame();
			return;
		end
		if (it.cmd == CMD_WRITE_MULTI) begin
			emit_frame_byte(8'h00);
			emit_frame_byte({1'b0, it.count});
			emit_frame_byte({it.count, 1'b0});
		end
		frame_open_model = 1'b1;
		emit_frame_byte(it.data);
		if (it.last)
			close_frame();
	endfunction

	// Request driver: offers the head of the pending queue and predicts on transfer.
	always @(posedge clk) begin
		logic took;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			took = req_ch.valid && req_ch.ready;
			if (took)
				predict_frame_bytes(pending_reqs.pop_front());
			if (!req_ch.valid || took) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_ch.cmd         <= pending_reqs[0].cmd;
					req_ch.start_addr  <= pending_reqs[0].addr;
					req_ch.num_regs    <= pending_reqs[0].count;
					req_ch.data_byte   <= pending_reqs[0].data;
					req_ch.end_of_data <= pending_reqs[0].last;
					req_ch.valid       <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted on its own.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (long_hold_req) begin
			hold_left <= LONG_HOLD_CYCLES;
			long_hold_req = 1'b0;
		end
	end

	// Frame byte monitor.
	always @(posedge clk) begin
		frame_byte_t want;
		if (!arst_n) begin
			frm_ch.ready <= 1'b0;
		end else begin
			if (frm_ch.valid && frm_ch.ready) begin
				if (expected_bytes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: unexpected byte: expected none, got out_byte %02h frame_end %b",
							$time, frm_ch.out_byte, frm_ch.frame_end);
				end else begin
					want = expected_bytes.pop_front();
					if (frm_ch.out_byte !== want.data || frm_ch.frame_end !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("%0t: expected out_byte %02h frame_end %b, got %02h %b",
								$time, want.data, want.last, frm_ch.out_byte,
								frm_ch.frame_end);
					end
				end
			end
			frm_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic void push_req(logic [1:0] cmd, logic [15:0] addr, logic [6:0] count,
		logic [7:0] data, logic last);
		req_item_t it;
		it = '{cmd, addr, count, data, last};
		pending_reqs.push_back(it);
	endfunction

	function automatic logic [6:0] random_count();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0)
			return 7'd0;
		if (pick == 1)
			return 7'($urandom_range(127, 126));
		return 7'($urandom_range(125, 1));
	endfunction

	// Queues one frame (or one stray reserved item) and returns how many
	// items in it reach the framer as real work.
	function automatic int queue_random_frame();
		int pick;
		int n_data;
		logic [1:0] kind;
		pick = $urandom_range(99);
		if (pick < 5) begin
			push_req(CMD_RESERVED, 16'($urandom), random_count(), 8'($urandom),
				1'($urandom));
			return 0;
		end
		if (pick < 30) begin
			push_req(CMD_READ_HOLD, 16'($urandom), random_count(), 8'($urandom),
				1'($urandom));
			return 1;
		end
		kind = (pick < 55) ? CMD_WRITE_SINGLE : CMD_WRITE_MULTI;
		n_data = ($urandom_range(9) == 0) ? $urandom_range(24, 8) : $urandom_range(4, 1);
		push_req(kind, 16'($urandom), random_count(), 8'($urandom), n_data == 1);
		for (int i = 1; i < n_data; i++)
			push_req(2'($urandom), 16'($urandom), 7'($urandom), 8'($urandom),
				i == n_data - 1);
		return n_data;
	endfunction

	task automatic queue_random_items(input int n);
		int done;
		done = 0;
		while (done < n)
			done += queue_random_frame();
	endtask

	task automatic wait_until_drained();
		while (pending_reqs.size() != 0 || expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_slave_address(input logic [7:0] value);
		wait_until_drained();
		// A trailing reserved item emits nothing, so give the block time to settle.
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.slave_address <= value;
		cfg_ch.valid         <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		slave_addr_model = value;
	endtask

	task automatic queue_directed_items();
		push_req(CMD_READ_HOLD, 16'h0000, 7'd1, 8'h00, 1'b0);
		push_req(CMD_READ_HOLD, 16'hFFFF, 7'd127, 8'hFF, 1'b1);
		push_req(CMD_READ_HOLD, 16'h1234, 7'd0, 8'h5A, 1'b0);
		push_req(CMD_RESERVED, 16'hABCD, 7'd5, 8'h77, 1'b1);
		push_req(CMD_WRITE_SINGLE, 16'hFFFF, 7'd0, 8'hFF, 1'b1);
		push_req(CMD_WRITE_SINGLE, 16'h0000, 7'd127, 8'h00, 1'b0);
		push_req(CMD_RESERVED, 16'h0000, 7'd0, 8'hA5, 1'b0);
		push_req(CMD_READ_HOLD, 16'h5555, 7'd3, 8'h3C, 1'b1);
		push_req(CMD_WRITE_MULTI, 16'h0100, 7'd125, 8'h12, 1'b0);
		push_req(CMD_WRITE_MULTI, 16'h0000, 7'd0, 8'h34, 1'b0);
		push_req(CMD_WRITE_SINGLE, 16'h0000, 7'd0, 8'h56, 1'b0);
		push_req(CMD_READ_HOLD, 16'h0000, 7'd0, 8'h78, 1'b1);
		push_req(CMD_WRITE_MULTI, 16'h8000, 7'd127, 8'hFF, 1'b1);
		push_req(CMD_WRITE_MULTI, 16'h00FF, 7'd0, 8'h00, 1'b0);
		push_req(CMD_WRITE_MULTI, 16'hFFFF, 7'd127, 8'h01, 1'b0);
		push_req(CMD_WRITE_SINGLE, 16'h0000, 7'd0, 8'h80, 1'b1);
		push_req(CMD_WRITE_MULTI, 16'hA5A5, 7'd64, 8'hC3, 1'b0);
		push_req(CMD_RESERVED, 16'hFFFF, 7'd127, 8'h3C, 1'b1);
		// More data bytes than the register count asks for.
		push_req(CMD_WRITE_MULTI, 16'h0002, 7'd2, 8'h11, 1'b0);
		push_req(CMD_READ_HOLD, 16'h0000, 7'd0, 8'h22, 1'b0);
		push_req(CMD_READ_HOLD, 16'h0000, 7'd0, 8'h33, 1'b0);
		push_req(CMD_READ_HOLD, 16'h0000, 7'd0, 8'h44, 1'b0);
		push_req(CMD_READ_HOLD, 16'h0000, 7'd0, 8'h55, 1'b0);
		push_req(CMD_READ_HOLD, 16'h0000, 7'd0, 8'h66, 1'b1);
		push_req(CMD_READ_HOLD, 16'h7E7E, 7'd125, 8'h99, 1'b0);
	endtask

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.cmd           = CMD_READ_HOLD;
		req_ch.start_addr    = 16'h0000;
		req_ch.num_regs      = 7'd0;
		req_ch.data_byte     = 8'h00;
		req_ch.end_of_data   = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.slave_address = 8'h00;
		frm_ch.ready         = 1'b0;
		slave_addr_model     = SLAVE_ADDR_RESET;
		crc_model            = CRC_INIT;
		frame_open_model     = 1'b0;
		send_idle_pct        = 0;
		recv_stall_pct       = 0;
		hold_left            = 0;
		long_hold_req        = 1'b0;
		mismatch_count       = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_directed_items();

		write_slave_address(8'h00);
		queue_random_items(100);

		write_slave_address(8'hFF);
		send_idle_pct = 88;
		queue_random_items(80);

		write_slave_address(8'($urandom));
		send_idle_pct  = 0;
		recv_stall_pct = 88;
		queue_random_items(40);
		// The sender stops here until the framer has delivered everything.
		wait_until_drained();
		queue_random_items(40);

		write_slave_address(8'($urandom));
		send_idle_pct  = 9;
		recv_stall_pct = 9;
		queue_random_items(80);
		long_hold_req = 1'b1;

		write_slave_address(SLAVE_ADDR_RESET);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		long_hold_req  = 1'b1;
		queue_random_items(80);

		wait_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_bytes.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#1000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
